[hdl/c_integer_literal_scanner_defines.svh]
// Assertion macros used by the back end module of the integer literal scanner.
`ifndef C_INTEGER_LITERAL_SCANNER_DEFINES_SVH
`define C_INTEGER_LITERAL_SCANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CILS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CILS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cils_pkg.sv]
// Types and constants shared by the integer literal scanner modules.
`default_nettype none

package cils_pkg;

   localparam int MAX_TOKEN_BYTES_DEFAULT = 255;
   localparam int QUEUE_DEPTH_DEFAULT     = 2;

   localparam logic [1:0] KIND_INTEGER = 2'd0;
   localparam logic [1:0] KIND_FLOAT   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [2:0] SUFFIX_NONE = 3'd0;
   localparam logic [2:0] SUFFIX_U    = 3'd1;
   localparam logic [2:0] SUFFIX_L    = 3'd2;
   localparam logic [2:0] SUFFIX_LL   = 3'd3;
   localparam logic [2:0] SUFFIX_UL   = 3'd4;
   localparam logic [2:0] SUFFIX_ULL  = 3'd5;

   localparam logic [4:0] NOT_HEX_DIGIT = 5'd16;

   typedef struct packed {
      logic       begins;
      logic       is_digit;
      logic [4:0] digit_value;
      logic       is_x;
      logic       is_u;
      logic       is_l;
      logic       is_dot;
      logic       is_p;
      logic       is_e;
   } class_type;

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [63:0] int_value;
      logic [1:0]  radix_code;
      logic [2:0]  suffix_code;
      logic [7:0]  token_length;
   } result_type;

endpackage

`default_nettype wire

[hdl/cils_fifo.sv]
// Small first-in first-out queue with the head shown ahead of the pop.
`default_nettype none

module cils_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cils_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/cils_front.sv]
// Front end: classifies each source byte and queues it for the scanner.
`default_nettype none

module cils_front #(
   parameter int QUEUE_DEPTH = cils_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [7:0]          char_byte,
   input  wire logic                begins_token,
   output logic                     full,
   input  wire logic                q_pop,
   output logic                     q_empty,
   output cils_pkg::class_type      q_item
);

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_LO_U  = 8'h75;
   localparam logic [7:0] CHAR_LO_L  = 8'h6c;
   localparam logic [7:0] CHAR_LO_P  = 8'h70;
   localparam logic [7:0] CHAR_LO_E  = 8'h65;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   cils_pkg::class_type item;
   logic [7:0]          lower;
   logic [$bits(cils_pkg::class_type)-1:0] q_bits;

   always_comb begin
      lower = ((char_byte >= CHAR_UP_A) && (char_byte <= CHAR_UP_Z)) ?
              char_byte + CASE_SHIFT : char_byte;
      item.begins   = begins_token;
      item.is_digit = (char_byte >= CHAR_0) && (char_byte <= CHAR_9);
      if (item.is_digit) begin
         item.digit_value = 5'(char_byte - CHAR_0);
      end else if ((char_byte >= CHAR_LO_A) && (char_byte <= CHAR_LO_F)) begin
         item.digit_value = 5'(char_byte - CHAR_LO_A) + 5'd10;
      end else if ((char_byte >= CHAR_UP_A) && (char_byte <= CHAR_UP_F)) begin
         item.digit_value = 5'(char_byte - CHAR_UP_A) + 5'd10;
      end else begin
         item.digit_value = cils_pkg::NOT_HEX_DIGIT;
      end
      item.is_x   = (lower == CHAR_LO_X);
      item.is_u   = (lower == CHAR_LO_U);
      item.is_l   = (lower == CHAR_LO_L);
      item.is_dot = (char_byte == CHAR_DOT);
      item.is_p   = (lower == CHAR_LO_P);
      item.is_e   = (lower == CHAR_LO_E);
   end

   cils_fifo #(
      .WIDTH ($bits(cils_pkg::class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (item),
      .full      (full),
      .pop       (q_pop),
      .pop_data  (q_bits),
      .empty     (q_empty)
   );

   assign q_item = cils_pkg::class_type'(q_bits);

endmodule

`default_nettype wire

[hdl/cils_back.sv]
// Back end: the constant scanner state machine and value accumulator.
`default_nettype none

`include "c_integer_literal_scanner_defines.svh"

module cils_back #(
   parameter int MAX_TOKEN_BYTES = cils_pkg::MAX_TOKEN_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_empty,
   output logic                      in_pop,
   input  wire cils_pkg::class_type  in_item,
   input  wire logic                 out_full,
   output logic                      out_push,
   output cils_pkg::result_type      out_item
);

   localparam int BCW = $clog2(MAX_TOKEN_BYTES + 1);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_ZERO   = 3'd1;
   localparam logic [2:0] PH_DEC    = 3'd2;
   localparam logic [2:0] PH_OCT    = 3'd3;
   localparam logic [2:0] PH_HEX0   = 3'd4;
   localparam logic [2:0] PH_HEX    = 3'd5;
   localparam logic [2:0] PH_SUFFIX = 3'd6;

   logic [2:0]     phase_ff, phase_in;
   logic [63:0]    acc_ff, acc_in;
   logic [1:0]     radix_ff, radix_in;
   logic [BCW-1:0] count_ff, count_in;
   logic [2:0]     u_ff, u_in, l_ff, l_in, ll_ff, ll_in, steps_ff, steps_in;
   logic           pend_ff, pend_in, failed_ff, failed_in;
   logic           emit_valid;
   logic           take;

   assign take     = !in_empty && !out_full;
   assign in_pop   = take;
   assign out_push = take && emit_valid;

   always_comb begin : scan_step
      logic       do_digit, do_suffix, suffix_done;
      logic       err_f, flt_f, int_f;
      logic       cx, cu, cl, cdot, cp, ce;
      logic [4:0] dv, base;
      logic [67:0] prod, sum;
      logic [2:0] code;

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      radix_in  = radix_ff;
      count_in  = count_ff;
      u_in      = u_ff;
      l_in      = l_ff;
      ll_in     = ll_ff;
      steps_in  = steps_ff;
      pend_in   = pend_ff;
      failed_in = failed_ff;
      do_digit    = 1'b0;
      do_suffix   = 1'b0;
      suffix_done = 1'b0;
      err_f       = 1'b0;
      flt_f       = 1'b0;
      int_f       = 1'b0;
      code        = cils_pkg::SUFFIX_NONE;
      emit_valid  = 1'b0;
      out_item    = '0;

      // A new token closes the open one as if a zero byte had arrived.
      if (in_item.begins) begin
         cx   = 1'b0;
         cu   = 1'b0;
         cl   = 1'b0;
         cdot = 1'b0;
         cp   = 1'b0;
         ce   = 1'b0;
         dv   = cils_pkg::NOT_HEX_DIGIT;
      end else begin
         cx   = in_item.is_x;
         cu   = in_item.is_u;
         cl   = in_item.is_l;
         cdot = in_item.is_dot;
         cp   = in_item.is_p;
         ce   = in_item.is_e;
         dv   = in_item.digit_value;
      end

      unique case (phase_ff)
         PH_ZERO: begin
            if (cx) begin
               if (count_in == BCW'(MAX_TOKEN_BYTES)) begin
                  err_f = 1'b1;
               end else begin
                  count_in = count_in + BCW'(1);
                  radix_in = cils_pkg::RADIX_HEX;
                  phase_in = PH_HEX0;
               end
            end else begin
               phase_in = PH_OCT;
               do_digit = 1'b1;
            end
         end
         PH_DEC, PH_OCT, PH_HEX0, PH_HEX: begin
            do_digit = 1'b1;
         end
         PH_SUFFIX: begin
            do_suffix = 1'b1;
         end
         default: begin
         end
      endcase

      if (radix_in == cils_pkg::RADIX_HEX) begin
         base = 5'd16;
         prod = {acc_in, 4'b0000};
      end else if (radix_in == cils_pkg::RADIX_OCT) begin
         base = 5'd8;
         prod = {1'b0, acc_in, 3'b000};
      end else begin
         base = 5'd10;
         prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0};
      end
      sum = prod + 68'(dv);

      if (do_digit) begin
         if (dv < base) begin
            if (count_in == BCW'(MAX_TOKEN_BYTES)) begin
               err_f = 1'b1;
            end else begin
               count_in = count_in + BCW'(1);
               if (!failed_in) begin
                  if (|sum[67:64]) begin
                     failed_in = 1'b1;
                  end else begin
                     acc_in = sum[63:0];
                  end
               end
               if (phase_in == PH_HEX0) begin
                  phase_in = PH_HEX;
               end
            end
         end else if (cdot || cp || ((radix_in != cils_pkg::RADIX_HEX) && ce)) begin
            flt_f = 1'b1;
         end else if (dv < cils_pkg::NOT_HEX_DIGIT) begin
            err_f = 1'b1;
         end else if (phase_in == PH_HEX0) begin
            err_f = 1'b1;
         end else if (failed_in) begin
            err_f = 1'b1;
         end else begin
            phase_in  = PH_SUFFIX;
            do_suffix = 1'b1;
         end
      end

      if (do_suffix) begin
         if (pend_in) begin
            pend_in  = 1'b0;
            steps_in = steps_in + 3'd1;
            if (cl) begin
               ll_in       = ll_in + 3'd1;
               suffix_done = 1'b1;
               if (count_in == BCW'(MAX_TOKEN_BYTES)) begin
                  err_f = 1'b1;
               end else begin
                  count_in = count_in + BCW'(1);
               end
            end else begin
               l_in = l_in + 3'd1;
            end
         end
         if (!suffix_done) begin
            if (cu || cl) begin
               if (steps_in > 3'd4) begin
                  err_f = 1'b1;
               end else if (count_in == BCW'(MAX_TOKEN_BYTES)) begin
                  err_f = 1'b1;
               end else begin
                  count_in = count_in + BCW'(1);
                  if (cu) begin
                     u_in     = u_in + 3'd1;
                     steps_in = steps_in + 3'd1;
                  end else begin
                     pend_in = 1'b1;
                  end
               end
            end else begin
               priority if ((u_in == 3'd0) && (l_in == 3'd0) && (ll_in == 3'd0)) begin
                  code  = cils_pkg::SUFFIX_NONE;
                  int_f = 1'b1;
               end else if ((u_in == 3'd1) && (l_in == 3'd0) && (ll_in == 3'd0)) begin
                  code  = cils_pkg::SUFFIX_U;
                  int_f = 1'b1;
               end else if ((u_in == 3'd0) && (l_in == 3'd1) && (ll_in == 3'd0)) begin
                  code  = cils_pkg::SUFFIX_L;
                  int_f = 1'b1;
               end else if ((u_in == 3'd0) && (l_in == 3'd0) && (ll_in == 3'd1)) begin
                  code  = cils_pkg::SUFFIX_LL;
                  int_f = 1'b1;
               end else if ((u_in == 3'd1) && (l_in == 3'd1) && (ll_in == 3'd0)) begin
                  code  = cils_pkg::SUFFIX_UL;
                  int_f = 1'b1;
               end else if ((u_in == 3'd1) && (l_in == 3'd0) && (ll_in == 3'd1)) begin
                  code  = cils_pkg::SUFFIX_ULL;
                  int_f = 1'b1;
               end else begin
                  err_f = 1'b1;
               end
            end
         end
      end

      if (err_f || flt_f || int_f) begin
         emit_valid = 1'b1;
         if (err_f) begin
            out_item.token_kind   = cils_pkg::KIND_ERROR;
            out_item.token_length = 8'd1;
         end else if (flt_f) begin
            out_item.token_kind = cils_pkg::KIND_FLOAT;
            out_item.radix_code = radix_in;
         end else begin
            out_item.token_kind   = cils_pkg::KIND_INTEGER;
            out_item.int_value    = acc_in;
            out_item.radix_code   = radix_in;
            out_item.suffix_code  = code;
            out_item.token_length = 8'(count_in);
         end
      end

      if (emit_valid || in_item.begins) begin
         phase_in  = PH_IDLE;
         acc_in    = '0;
         radix_in  = cils_pkg::RADIX_DEC;
         count_in  = '0;
         u_in      = '0;
         l_in      = '0;
         ll_in     = '0;
         steps_in  = '0;
         pend_in   = 1'b0;
         failed_in = 1'b0;
      end

      if (in_item.begins && in_item.is_digit) begin
         count_in = BCW'(1);
         if (in_item.digit_value == 5'd0) begin
            phase_in = PH_ZERO;
            radix_in = cils_pkg::RADIX_OCT;
         end else begin
            phase_in = PH_DEC;
            radix_in = cils_pkg::RADIX_DEC;
            acc_in   = 64'(in_item.digit_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         acc_ff    <= '0;
         radix_ff  <= cils_pkg::RADIX_DEC;
         count_ff  <= '0;
         u_ff      <= '0;
         l_ff      <= '0;
         ll_ff     <= '0;
         steps_ff  <= '0;
         pend_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         radix_ff  <= radix_in;
         count_ff  <= count_in;
         u_ff      <= u_in;
         l_ff      <= l_in;
         ll_ff     <= ll_in;
         steps_ff  <= steps_in;
         pend_ff   <= pend_in;
         failed_ff <= failed_in;
      end
   end

   `CILS_ASSERT_SAME(a_idle_is_clear, clock, reset, phase_ff == PH_IDLE,
      (count_ff == '0) && !pend_ff && !failed_ff && (acc_ff == '0),
      "Idle scanner holds leftover token state.")
   `CILS_ASSERT_SAME(a_pending_in_suffix, clock, reset, pend_ff,
      phase_ff == PH_SUFFIX, "A pending l outside the suffix phase.")
   `CILS_ASSERT_SAME(a_suffix_bounded, clock, reset, phase_ff != PH_IDLE,
      (steps_ff <= 3'd5) && (count_ff <= BCW'(MAX_TOKEN_BYTES)),
      "Suffix steps or token length beyond their limits.")
   `CILS_ASSERT_NEXT(a_digit_opens_token, clock, reset,
      take && in_item.begins && in_item.is_digit, phase_ff != PH_IDLE,
      "A starting digit did not open a token.")

endmodule

`default_nettype wire

[hdl/c_integer_literal_scanner.sv]
// Top level of the C integer constant scanner.
// Source bytes enter through a queue-like port: drive req_char_byte and
// req_begins_token and raise req_push; the byte is taken at a clock edge where
// req_full is low. Set req_begins_token on the first digit of each constant.
// Results leave through a second queue-like port: while rsp_empty is low the
// oldest result is on the rsp_ ports and is taken at an edge with rsp_pop high.
// A token gives at most one result, on the byte that ends it: an integer with
// value, radix, suffix and length, a handoff to floating point, or an error.
// The front end classifies each byte into a QUEUE_DEPTH-entry queue (two by
// default); the back end runs the scanner at one byte per clock while the byte
// queue is not empty and the result queue is not full, its multiply-add by the
// radix done as combinational shifts and adds. A result is written to the result
// queue at the edge where the back end takes the byte that ends the token. When
// the receiver holds rsp_pop low the result queue fills, the scanner stops, and
// then the byte queue fills and req_full rises. Synchronous reset empties both
// queues and returns the scanner to idle.
`default_nettype none

module c_integer_literal_scanner #(
   parameter int MAX_TOKEN_BYTES = cils_pkg::MAX_TOKEN_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH     = cils_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_begins_token,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_token_kind,
   output logic [63:0]      rsp_int_value,
   output logic [1:0]       rsp_radix_code,
   output logic [2:0]       rsp_suffix_code,
   output logic [7:0]       rsp_token_length
);

   cils_pkg::class_type  q_item;
   cils_pkg::result_type res_item, head_item;
   logic                 q_empty, q_pop, res_full, res_push;
   logic [$bits(cils_pkg::result_type)-1:0] head_bits;

   cils_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .char_byte    (req_char_byte),
      .begins_token (req_begins_token),
      .full         (req_full),
      .q_pop        (q_pop),
      .q_empty      (q_empty),
      .q_item       (q_item)
   );

   cils_back #(
      .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_empty (q_empty),
      .in_pop   (q_pop),
      .in_item  (q_item),
      .out_full (res_full),
      .out_push (res_push),
      .out_item (res_item)
   );

   cils_fifo #(
      .WIDTH ($bits(cils_pkg::result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_results (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_item),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (head_bits),
      .empty     (rsp_empty)
   );

   assign head_item        = cils_pkg::result_type'(head_bits);
   assign rsp_token_kind   = head_item.token_kind;
   assign rsp_int_value    = head_item.int_value;
   assign rsp_radix_code   = head_item.radix_code;
   assign rsp_suffix_code  = head_item.suffix_code;
   assign rsp_token_length = head_item.token_length;

endmodule

`default_nettype wire

[verif/c_integer_literal_scanner_tb.sv]
// Self-checking testbench for the C integer constant scanner: directed and random byte streams.
`timescale 1ns / 1ps

module c_integer_literal_scanner_tb;

   localparam int MAX_BYTES = cils_pkg::MAX_TOKEN_BYTES_DEFAULT;

   typedef struct packed {
      logic [7:0]           ch;
      logic                 bgn;
      logic                 typed;
      cils_pkg::result_type want;
   } source_row_type;

   typedef enum logic [2:0] {
      LX_IDLE, LX_ZERO, LX_DEC, LX_OCT, LX_HEX_PREFIX, LX_HEX, LX_SUFFIX
   } lex_phase_type;

   localparam cils_pkg::result_type NO_TOKEN = '0;

   localparam source_row_type OPENING_ROWS [27] = '{
      '{"0",   1'b1, 1'b0, NO_TOKEN},
      '{" ",   1'b0, 1'b1, '{cils_pkg::KIND_INTEGER, 64'd0, cils_pkg::RADIX_OCT,
                             cils_pkg::SUFFIX_NONE, 8'd1}},
      '{"0",   1'b1, 1'b0, NO_TOKEN},
      '{"x",   1'b0, 1'b0, NO_TOKEN},
      '{"g",   1'b0, 1'b1, '{cils_pkg::KIND_ERROR, 64'd0, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_NONE, 8'd1}},
      '{"0",   1'b1, 1'b0, NO_TOKEN},
      '{"9",   1'b0, 1'b1, '{cils_pkg::KIND_ERROR, 64'd0, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_NONE, 8'd1}},
      '{"7",   1'b1, 1'b0, NO_TOKEN},
      '{".",   1'b0, 1'b1, '{cils_pkg::KIND_FLOAT, 64'd0, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_NONE, 8'd0}},
      '{"9",   1'b1, 1'b0, NO_TOKEN},
      '{"U",   1'b0, 1'b0, NO_TOKEN},
      '{"L",   1'b0, 1'b0, NO_TOKEN},
      '{"L",   1'b0, 1'b0, NO_TOKEN},
      '{";",   1'b0, 1'b1, '{cils_pkg::KIND_INTEGER, 64'd9, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_ULL, 8'd4}},
      '{"1",   1'b1, 1'b0, NO_TOKEN},
      '{"l",   1'b0, 1'b0, NO_TOKEN},
      '{"u",   1'b0, 1'b0, NO_TOKEN},
      '{"l",   1'b0, 1'b0, NO_TOKEN},
      '{8'h00, 1'b0, 1'b1, '{cils_pkg::KIND_ERROR, 64'd0, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_NONE, 8'd1}},
      '{"5",   1'b1, 1'b0, NO_TOKEN},
      '{"3",   1'b1, 1'b1, '{cils_pkg::KIND_INTEGER, 64'd5, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_NONE, 8'd1}},
      '{"a",   1'b1, 1'b1, '{cils_pkg::KIND_INTEGER, 64'd3, cils_pkg::RADIX_DEC,
                             cils_pkg::SUFFIX_NONE, 8'd1}},
      '{"q",   1'b0, 1'b0, NO_TOKEN},
      '{"0",   1'b1, 1'b0, NO_TOKEN},
      '{"X",   1'b0, 1'b0, NO_TOKEN},
      '{"f",   1'b0, 1'b0, NO_TOKEN},
      '{")",   1'b0, 1'b1, '{cils_pkg::KIND_INTEGER, 64'd15, cils_pkg::RADIX_HEX,
                             cils_pkg::SUFFIX_NONE, 8'd3}}
   };

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_char_byte;
   logic        req_begins_token;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_token_kind;
   logic [63:0] rsp_int_value;
   logic [1:0]  rsp_radix_code;
   logic [2:0]  rsp_suffix_code;
   logic [7:0]  rsp_token_length;

   source_row_type       source_bytes[$];
   cils_pkg::result_type tokens_due[$];
   int                   bytes_taken;
   int                   mismatches;
   bit                   calm;

   string limit_texts[$] = '{"18446744073709551615", "18446744073709551616",
      "0xffffffffffffffff", "0XFFFFFFFFFFFFFFFF0", "01777777777777777777777",
      "02000000000000000000000", "0x0000000000000000000001"};
   string suffix_texts[$] = '{"u", "U", "l", "L", "ll", "LL", "lL", "ul", "lu", "Ul",
      "uLL", "llu", "LLU", "ull", "lul", "uu"};
   string hex_chars = "0123456789abcdefABCDEF";
   string bad_chars = "89abcdfABCDFgG";
   string stop_chars = " ;,)]+-*";
   string float_chars = ".eEpP";
   string letter_chars = "uUlL";

   lex_phase_type        lx_phase;
   logic [63:0]          lx_acc;
   logic [1:0]           lx_radix;
   int                   lx_len;
   int                   lx_u;
   int                   lx_l;
   int                   lx_ll;
   int                   lx_steps;
   bit                   lx_l_open;
   bit                   lx_ovf;
   bit                   token_ready;
   cils_pkg::result_type token_out;

   c_integer_literal_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_byte    (req_char_byte),
      .req_begins_token (req_begins_token),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_int_value    (rsp_int_value),
      .rsp_radix_code   (rsp_radix_code),
      .rsp_suffix_code  (rsp_suffix_code),
      .rsp_token_length (rsp_token_length)
   );

   function automatic logic [7:0] lower(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? 8'(b + 8'd32) : b;
   endfunction

   function automatic int digit_of(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return 16;
   endfunction

   function automatic void lex_clear();
      lx_phase = LX_IDLE;
      lx_acc = '0;
      lx_radix = cils_pkg::RADIX_DEC;
      lx_len = 0;
      lx_u = 0;
      lx_l = 0;
      lx_ll = 0;
      lx_steps = 0;
      lx_l_open = 1'b0;
      lx_ovf = 1'b0;
   endfunction

   function automatic void lex_emit(input logic [1:0] kind, input logic [63:0] val,
                                    input logic [1:0] radix, input logic [2:0] suf,
                                    input logic [7:0] len);
      token_out = '{kind, val, radix, suf, len};
      token_ready = 1'b1;
      lex_clear();
   endfunction

   function automatic void lex_fail();
      lex_emit(cils_pkg::KIND_ERROR, 64'd0, cils_pkg::RADIX_DEC, cils_pkg::SUFFIX_NONE, 8'd1);
   endfunction

   function automatic bit lex_grow();
      if (lx_len <= MAX_BYTES) lx_len++;
      return lx_len > MAX_BYTES;
   endfunction

   function automatic void lex_finish();
      logic [2:0] code;
      if (lx_u == 0 && lx_l == 0 && lx_ll == 0) code = cils_pkg::SUFFIX_NONE;
      else if (lx_u == 1 && lx_l == 0 && lx_ll == 0) code = cils_pkg::SUFFIX_U;
      else if (lx_u == 0 && lx_l == 1 && lx_ll == 0) code = cils_pkg::SUFFIX_L;
      else if (lx_u == 0 && lx_l == 0 && lx_ll == 1) code = cils_pkg::SUFFIX_LL;
      else if (lx_u == 1 && lx_l == 1 && lx_ll == 0) code = cils_pkg::SUFFIX_UL;
      else if (lx_u == 1 && lx_l == 0 && lx_ll == 1) code = cils_pkg::SUFFIX_ULL;
      else begin
         lex_fail();
         return;
      end
      lex_emit(cils_pkg::KIND_INTEGER, lx_acc, lx_radix, code, 8'(lx_len));
   endfunction

   function automatic void lex_suffix(input logic [7:0] c);
      if (lx_l_open) begin
         lx_l_open = 1'b0;
         lx_steps++;
         if (c == "l") begin
            lx_ll++;
            if (lex_grow()) lex_fail();
            return;
         end
         lx_l++;
      end
      if (c == "u" || c == "l") begin
         if (lx_steps > 4 || lex_grow()) begin
            lex_fail();
            return;
         end
         if (c == "u") begin
            lx_u++;
            lx_steps++;
         end else begin
            lx_l_open = 1'b1;
         end
      end else begin
         lex_finish();
      end
   endfunction

   function automatic void lex_digit(input logic [7:0] b);
      int          base;
      int          d;
      logic [7:0]  c;
      logic [67:0] wide;
      base = (lx_radix == cils_pkg::RADIX_HEX) ? 16 :
             (lx_radix == cils_pkg::RADIX_OCT) ? 8 : 10;
      d = digit_of(b);
      c = lower(b);
      if (d < base) begin
         if (lex_grow()) begin
            lex_fail();
            return;
         end
         if (!lx_ovf) begin
            wide = {4'd0, lx_acc} * 68'(base) + 68'(d);
            if (wide[67:64] != 4'd0) lx_ovf = 1'b1;
            else lx_acc = wide[63:0];
         end
         if (lx_phase == LX_HEX_PREFIX) lx_phase = LX_HEX;
      end else if (b == "." || c == "p" || (lx_radix != cils_pkg::RADIX_HEX && c == "e")) begin
         lex_emit(cils_pkg::KIND_FLOAT, 64'd0, lx_radix, cils_pkg::SUFFIX_NONE, 8'd0);
      end else if (d < 16 || lx_phase == LX_HEX_PREFIX || lx_ovf) begin
         lex_fail();
      end else begin
         lx_phase = LX_SUFFIX;
         lex_suffix(c);
      end
   endfunction

   function automatic void lex_advance(input logic [7:0] b);
      case (lx_phase)
         LX_ZERO: begin
            if (lower(b) == "x") begin
               if (lex_grow()) begin
                  lex_fail();
               end else begin
                  lx_radix = cils_pkg::RADIX_HEX;
                  lx_phase = LX_HEX_PREFIX;
               end
            end else begin
               lx_phase = LX_OCT;
               lex_digit(b);
            end
         end
         LX_DEC, LX_OCT, LX_HEX_PREFIX, LX_HEX: begin
            lex_digit(b);
         end
         LX_SUFFIX: begin
            lex_suffix(lower(b));
         end
         default: begin
            lex_clear();
         end
      endcase
   endfunction

   function automatic void lex_byte(input logic [7:0] b, input logic bgn);
      token_ready = 1'b0;
      if (!bgn) begin
         if (lx_phase != LX_IDLE) lex_advance(b);
         return;
      end
      if (lx_phase != LX_IDLE) lex_advance(8'h00);
      lex_clear();
      if (b >= "0" && b <= "9") begin
         lx_len = 1;
         if (b == "0") begin
            lx_phase = LX_ZERO;
            lx_radix = cils_pkg::RADIX_OCT;
         end else begin
            lx_phase = LX_DEC;
            lx_radix = cils_pkg::RADIX_DEC;
            lx_acc = 64'(b - "0");
         end
      end
   endfunction

   function automatic void add_byte(input logic [7:0] ch, input logic bgn);
      source_bytes.push_back('{ch, bgn, 1'b0, NO_TOKEN});
   endfunction

   function automatic void add_token();
      int         pick;
      int         n;
      string      text;
      logic [7:0] q[$];
      pick = $urandom_range(99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 4))
            add_byte(8'($urandom_range(255)), $urandom_range(2) == 0);
         return;
      end
      if (pick < 11) begin
         text = limit_texts[$urandom_range(limit_texts.size() - 1)];
         for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
      end else if (pick < 13) begin
         q.push_back("0");
         repeat ($urandom_range(MAX_BYTES - 7, MAX_BYTES + 1)) q.push_back("0");
      end else begin
         n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
         case ($urandom_range(2))
            0: begin
               q.push_back(8'("1" + $urandom_range(8)));
               repeat (n) q.push_back(8'("0" + $urandom_range(9)));
            end
            1: begin
               q.push_back("0");
               repeat (n) q.push_back(8'("0" + $urandom_range(7)));
            end
            default: begin
               q.push_back("0");
               q.push_back(($urandom_range(1) == 0) ? 8'("x") : 8'("X"));
               repeat (n) q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
            end
         endcase
         if ($urandom_range(11) == 0)
            q.insert($urandom_range(1, q.size()), bad_chars[$urandom_range(bad_chars.len() - 1)]);
      end
      case ($urandom_range(3))
         1, 2: begin
            text = suffix_texts[$urandom_range(suffix_texts.size() - 1)];
            for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
         end
         3: begin
            repeat ($urandom_range(1, 7)) q.push_back(letter_chars[$urandom_range(3)]);
         end
         default: begin
         end
      endcase
      pick = $urandom_range(15);
      if (pick < 8) q.push_back(stop_chars[pick]);
      else if (pick == 8) q.push_back(8'h00);
      else if (pick < 12) q.push_back(float_chars[$urandom_range(float_chars.len() - 1)]);
      else if (pick < 14) q.push_back(8'($urandom_range(255)));
      foreach (q[i]) add_byte(q[i], i == 0);
   endfunction

   function automatic void flag_mismatch(input string why, input cils_pkg::result_type want,
                                         input cils_pkg::result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected %0d/%h/%0d/%0d/%0d, got %0d/%h/%0d/%0d/%0d",
                  $time, why, want.token_kind, want.int_value, want.radix_code,
                  want.suffix_code, want.token_length, got.token_kind, got.int_value,
                  got.radix_code, got.suffix_code, got.token_length);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_pop <= calm || $urandom_range(99) >= 29;
      end
   end

   always @(posedge clock) begin : watch
      source_row_type       row;
      cils_pkg::result_type got;
      cils_pkg::result_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_token_kind, rsp_int_value, rsp_radix_code, rsp_suffix_code,
                    rsp_token_length};
            if (tokens_due.size() == 0) begin
               flag_mismatch("result with none expected", NO_TOKEN, got);
            end else begin
               want = tokens_due.pop_front();
               if (got.token_kind !== want.token_kind || got.int_value !== want.int_value ||
                   got.radix_code !== want.radix_code ||
                   got.suffix_code !== want.suffix_code ||
                   got.token_length !== want.token_length)
                  flag_mismatch("wrong result", want, got);
            end
         end
         if (req_push && !req_full) begin
            row = source_bytes[bytes_taken];
            bytes_taken++;
            lex_byte(row.ch, row.bgn);
            if (row.typed) tokens_due.push_back(row.want);
            else if (token_ready) tokens_due.push_back(token_out);
         end
      end
   end

   initial begin : drive
      bit quiet;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_char_byte <= 8'h00;
      req_begins_token <= 1'b0;
      lex_clear();
      foreach (OPENING_ROWS[i]) source_bytes.push_back(OPENING_ROWS[i]);
      while (source_bytes.size() < $size(OPENING_ROWS) + 700) add_token();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < source_bytes.size(); i++) begin
         quiet = i >= 300 && i < 450;
         calm <= quiet;
         while (!quiet && $urandom_range(99) < 29) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
         req_push <= 1'b1;
         req_char_byte <= source_bytes[i].ch;
         req_begins_token <= source_bytes[i].bgn;
         @(posedge clock);
         while (req_full) @(posedge clock);
      end
      req_push <= 1'b0;
      for (int w = 0; w < 2000 && tokens_due.size() != 0; w++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tokens_due.size() != 0) begin
         $display("%0d expected results never arrived", tokens_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
